// ===== hdl/evsa_pkg.sv =====
// Package: shared types, codes and constants for the eased viewport scroll animator.
package evsa_pkg;

  localparam int unsigned TileWDef    = 24;
  localparam int unsigned TileHDef    = 24;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 12;
  localparam logic [11:0] ViewWReset  = 12'd640;
  localparam logic [11:0] ViewHReset  = 12'd400;
  localparam logic [CfgIdxW-1:0] CfgViewW = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgViewH = 1'd1;

  typedef enum logic [2:0] {
    OP_SCROLL_TO   = 3'd0,
    OP_CENTER_ON   = 3'd1,
    OP_CENTER_CELL = 3'd2,
    OP_JUMP_CELL   = 3'd3,
    OP_CANCEL      = 3'd4,
    OP_TICK        = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    EASE_INSTANT = 2'd0,
    EASE_LINEAR  = 2'd1,
    EASE_QUAD    = 2'd2,
    EASE_SMOOTH  = 2'd3
  } ease_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic [1:0]         ease_mode;
    logic [15:0]        frame_count;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] view_x;
    logic signed [15:0] view_y;
    logic               busy_res;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_DIV, ST_EASE1, ST_EASE2, ST_EASE3,
    ST_MUL, ST_APPLY, ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the input item
    logic decode;    // run command decode / latch target
    logic div_start;
    logic ease1;
    logic ease2;
    logic ease3;
    logic mul;
    logic apply;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic need_tick;  // item is a tick of a running animation
    logic div_done;
  } sts_t;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) return 16'sh7fff;
    if (v < -32'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

// ===== hdl/evsa_ctrl.sv =====
// Controller: sequences decode, the progress divide, easing and interpolation.
module evsa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  evsa_pkg::sts_t  sts_i,
  output evsa_pkg::ctl_t  ctl_o
);
  import evsa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctl_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        ctl_o.decode = 1'b1;
        if (sts_i.need_tick) begin
          ctl_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIV:   if (sts_i.div_done) state_d = ST_EASE1;
      ST_EASE1: begin ctl_o.ease1 = 1'b1; state_d = ST_EASE2; end
      ST_EASE2: begin ctl_o.ease2 = 1'b1; state_d = ST_EASE3; end
      ST_EASE3: begin ctl_o.ease3 = 1'b1; state_d = ST_MUL; end
      ST_MUL:   begin ctl_o.mul = 1'b1; state_d = ST_APPLY; end
      ST_APPLY: begin ctl_o.apply = 1'b1; state_d = ST_OUT; end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !sts_i.div_done) |=> state_q == ST_DIV)
    else $error("left divide early");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output overlap");
endmodule

// ===== hdl/evsa_dp.sv =====
// Datapath: command decode, restoring divider, ease curve and interpolation.
module evsa_dp #(
  parameter int unsigned TileW    = evsa_pkg::TileWDef,
  parameter int unsigned TileH    = evsa_pkg::TileHDef,
  parameter int unsigned FracBits = evsa_pkg::FracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  evsa_pkg::in_item_t             item_i,
  input  logic                           cfg_we_i,
  input  logic [evsa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [evsa_pkg::CfgDataW-1:0]  cfg_data_i,
  input  evsa_pkg::ctl_t                 ctl_i,
  output evsa_pkg::sts_t                 sts_o,
  output evsa_pkg::out_item_t            res_o
);
  import evsa_pkg::*;

  localparam int unsigned EW   = FracBits + 1;         // Q1.F width
  localparam int unsigned QW   = 16 + FracBits;        // quotient bits
  localparam int unsigned CntW = $clog2(QW + 1);
  localparam logic [EW-1:0] One = EW'(1) << FracBits;

  logic [11:0] vw_q, vh_q;
  in_item_t    it_q;
  logic signed [15:0] cur_x_q, cur_y_q, org_x_q, org_y_q, goal_x_q, goal_y_q;
  logic [1:0]  curve_q;
  logic [15:0] span_q, elap_q;
  logic        run_q;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw_q <= ViewWReset;
      vh_q <= ViewHReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgViewW) vw_q <= cfg_data_i;
      if (cfg_idx_i == CfgViewH) vh_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) it_q <= item_i;
  end

  // targets
  logic signed [31:0] cx, cy, hw, hh, tx, ty, jx, jy;
  logic starts, instant;
  always_comb begin
    cx = 32'(it_q.coord_x);
    cy = 32'(it_q.coord_y);
    hw = {21'd0, vw_q[11:1]};
    hh = {21'd0, vh_q[11:1]};
    jx = cx * $signed(32'(TileW));
    jy = cy * $signed(32'(TileH));
    starts = 1'b0;
    case (opcode_e'(it_q.opcode))
      OP_SCROLL_TO: begin tx = cx; ty = cy; starts = 1'b1; end
      OP_CENTER_ON: begin tx = cx - hw; ty = cy - hh; starts = 1'b1; end
      OP_CENTER_CELL: begin
        tx = jx + 32'(TileW / 2) - hw;
        ty = jy + 32'(TileH / 2) - hh;
        starts = 1'b1;
      end
      default: begin tx = cx; ty = cy; end
    endcase
    instant = (it_q.ease_mode == EASE_INSTANT) || (it_q.frame_count == 16'd0);
  end

  logic [15:0] elap_inc;
  assign elap_inc = elap_q + 16'd1;
  assign sts_o.need_tick = (opcode_e'(it_q.opcode) == OP_TICK) && run_q;

  // divider: elapsed<<F / span, restoring, one bit per cycle
  logic [QW-1:0] dq_q;
  logic [16:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic          dbusy_q, at_end_q;
  logic [16:0]   rsh;
  logic          dge;
  assign rsh = {rem_q[15:0], dq_q[QW-1]};
  assign dge = rsh >= {1'b0, span_q};
  assign sts_o.div_done = dbusy_q && (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      cnt_q   <= '0;
    end else if (ctl_i.div_start) begin
      dbusy_q <= 1'b1;
      cnt_q   <= CntW'(QW);
    end else if (dbusy_q) begin
      if (cnt_q == '0) dbusy_q <= 1'b0;
      else cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.div_start) begin
      dq_q     <= {elap_inc, {FracBits{1'b0}}};
      rem_q    <= '0;
      at_end_q <= (span_q == 16'd0) || (elap_inc >= span_q);
    end else if (dbusy_q && cnt_q != '0) begin
      rem_q <= dge ? rsh - {1'b0, span_q} : rsh;
      dq_q  <= {dq_q[QW-2:0], dge};
    end
  end

  // easing: three registered steps
  logic [EW-1:0] t_q, u_q, e_q;
  logic [2*EW-1:0] sq_q;
  logic [2*EW-1:0] uu;
  logic [EW:0]   k;
  logic [2*EW+1:0] prod;
  assign uu   = (2*EW)'(u_q) * (2*EW)'(u_q);
  assign k    = (EW+1)'(3) * (EW+1)'(One) - {t_q, 1'b0};
  assign prod = (2*EW+2)'(sq_q[EW-1+FracBits:FracBits]) * (2*EW+2)'(k);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ease1) begin
      t_q <= (at_end_q || dq_q > QW'(One)) ? One : dq_q[EW-1:0];
    end
    if (ctl_i.ease2) begin
      u_q  <= One - t_q;
      sq_q <= t_q * t_q;
    end
    if (ctl_i.ease3) begin
      case (ease_e'(curve_q))
        EASE_LINEAR: e_q <= t_q;
        EASE_QUAD: e_q <= One - EW'(uu >> FracBits);
        EASE_SMOOTH: e_q <= EW'(prod >> FracBits);
        default: e_q <= One;
      endcase
    end
  end

  // interpolation
  logic signed [16:0] dx, dy;
  logic [16:0] mx, my;
  logic [17+EW-1:0] px_q, py_q;
  assign dx = 17'(goal_x_q) - 17'(org_x_q);
  assign dy = 17'(goal_y_q) - 17'(org_y_q);
  assign mx = dx[16] ? 17'(-dx) : 17'(dx);
  assign my = dy[16] ? 17'(-dy) : 17'(dy);
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      px_q <= (17+EW)'(mx) * (17+EW)'(e_q);
      py_q <= (17+EW)'(my) * (17+EW)'(e_q);
    end
  end
  logic signed [31:0] stx, sty, nx, ny;
  assign stx = 32'(px_q >> FracBits);
  assign sty = 32'(py_q >> FracBits);
  assign nx  = 32'(org_x_q) + (dx[16] ? -stx : stx);
  assign ny  = 32'(org_y_q) + (dy[16] ? -sty : sty);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0; cur_y_q <= '0; org_x_q <= '0; org_y_q <= '0;
      goal_x_q <= '0; goal_y_q <= '0; curve_q <= '0;
      span_q <= '0; elap_q <= '0; run_q <= 1'b0;
    end else if (ctl_i.decode) begin
      if (starts) begin
        if (instant) begin
          run_q <= 1'b0;
          cur_x_q <= sat16(tx); cur_y_q <= sat16(ty);
        end else begin
          org_x_q <= cur_x_q; org_y_q <= cur_y_q;
          goal_x_q <= sat16(tx); goal_y_q <= sat16(ty);
          curve_q <= it_q.ease_mode; span_q <= it_q.frame_count;
          elap_q <= '0; run_q <= 1'b1;
        end
      end else if (opcode_e'(it_q.opcode) == OP_JUMP_CELL) begin
        run_q <= 1'b0;
        cur_x_q <= sat16(jx); cur_y_q <= sat16(jy);
      end else if (opcode_e'(it_q.opcode) == OP_CANCEL) begin
        run_q <= 1'b0;
      end else if (sts_o.need_tick) begin
        elap_q <= elap_inc;
      end
    end else if (ctl_i.ease1) begin
      if (at_end_q) run_q <= 1'b0;
    end else if (ctl_i.apply) begin
      cur_x_q <= sat16(nx); cur_y_q <= sat16(ny);
    end
  end

  assign res_o.view_x   = cur_x_q;
  assign res_o.view_y   = cur_y_q;
  assign res_o.busy_res = run_q;

  a_t_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.ease2 |-> t_q <= One)
    else $error("progress above one");
  a_end_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.ease1 && at_end_q) |=> !run_q)
    else $error("animation did not end");
  a_busy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.div_start |-> run_q)
    else $error("tick while idle");
endmodule

// ===== hdl/eased_viewport_scroll_animator.sv =====
// Top level: eased viewport scroll animator.
// Usage:
//  - One input channel (in_valid_i/in_ready_o, payload in_item_i) carries
//    commands: scroll to, center on, center on cell, jump to cell, cancel
//    and frame tick. Every item yields exactly one result item on the
//    output channel (out_valid_o/out_ready_i, payload out_item_o): the
//    position after the command and the busy flag.
//  - One item is processed at a time. A non-tick command passes through
//    accept, decode and the result state. A tick of a running animation
//    passes through accept, decode, the bit-serial progress divide
//    (16 + FracBits quotient steps plus a done state), three ease steps,
//    one multiply, one apply and the result state.
//  - in_ready_o is high only when the block is idle; a stalled result
//    holds the block and its payload until out_ready_i.
//  - Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) writes view width
//    (index 0) and height (index 1); used for centering.
//  - Reset (rst_ni, async low) zeroes position and animation state and
//    loads width 640 and height 400. No clearing pass.
module eased_viewport_scroll_animator #(
  parameter int unsigned TileW    = evsa_pkg::TileWDef,
  parameter int unsigned TileH    = evsa_pkg::TileHDef,
  parameter int unsigned FracBits = evsa_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  evsa_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output evsa_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [evsa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [evsa_pkg::CfgDataW-1:0] cfg_data_i
);
  import evsa_pkg::*;

  ctl_t ctl;
  sts_t sts;

  evsa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  evsa_dp #(.TileW(TileW), .TileH(TileH), .FracBits(FracBits)) u_dp (
    .clk_i, .rst_ni, .item_i(in_item_i), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .ctl_i(ctl), .sts_o(sts), .res_o(out_item_o)
  );
endmodule

// ===== tb/eased_viewport_scroll_animator_tb.sv =====
// Testbench: eased viewport scroll animator, predicted and checked item by item.
module eased_viewport_scroll_animator_tb;
  import evsa_pkg::*;

  localparam int unsigned TileW    = 24;
  localparam int unsigned TileH    = 24;
  localparam int unsigned FracBits = 16;
  localparam longint unsigned One  = 64'd1 << FracBits;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_item_t            in_item_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  eased_viewport_scroll_animator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor copy of the block's state and viewport registers.
  logic [11:0]        pv_width, pv_height;
  logic signed [15:0] pos_x, pos_y, org_x, org_y, dst_x, dst_y;
  logic [1:0]         pv_curve;
  logic [15:0]        pv_span, pv_elapsed;
  logic               pv_running;

  out_item_t expected_views[$];
  int        fail_count = 0;
  int        items_sent = 0;
  int        views_checked = 0;
  int        ticks_sent = 0;
  bit        long_stalls = 1'b0;

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint unsigned eased(longint unsigned t, logic [1:0] c);
    longint unsigned u, s;
    case (c)
      EASE_LINEAR: return t;
      EASE_QUAD: begin
        u = One - t;
        return One - ((u * u) >> FracBits);
      end
      EASE_SMOOTH: begin
        s = (t * t) >> FracBits;
        return (s * (3 * One - 2 * t)) >> FracBits;
      end
      default: return One;
    endcase
  endfunction

  function automatic logic signed [15:0] blend(logic signed [15:0] a, logic signed [15:0] b,
                                               longint unsigned e);
    longint d, stp;
    longint unsigned mag;
    d   = longint'(b) - longint'(a);
    mag = (d < 0) ? -d : d;
    stp = longint'((mag * e) >> FracBits);
    return clip16(longint'(a) + ((d < 0) ? -stp : stp));
  endfunction

  task automatic launch_move(logic signed [15:0] tx, logic signed [15:0] ty,
                             logic [1:0] mode, logic [15:0] frames);
    if (mode == EASE_INSTANT || frames == 0) begin
      pv_running = 1'b0;
      pos_x = tx;
      pos_y = ty;
    end else begin
      org_x = pos_x; org_y = pos_y;
      dst_x = tx; dst_y = ty;
      pv_curve = mode; pv_span = frames;
      pv_elapsed = '0;
      pv_running = 1'b1;
    end
  endtask

  task automatic advance_frame();
    longint unsigned t, e;
    if (!pv_running) return;
    pv_elapsed = pv_elapsed + 16'd1;
    if (pv_span == 0 || pv_elapsed >= pv_span) begin
      t = One;
      pv_running = 1'b0;
    end else begin
      t = (longint'(pv_elapsed) << FracBits) / pv_span;
      if (t > One) t = One;
    end
    e = eased(t, pv_curve);
    pos_x = blend(org_x, dst_x, e);
    pos_y = blend(org_y, dst_y, e);
  endtask

  task automatic predict_view(in_item_t it);
    longint cx, cy, hw, hh;
    out_item_t r;
    cx = it.coord_x; cy = it.coord_y;
    hw = pv_width / 2; hh = pv_height / 2;
    case (it.opcode)
      OP_SCROLL_TO:   launch_move(clip16(cx), clip16(cy), it.ease_mode, it.frame_count);
      OP_CENTER_ON:   launch_move(clip16(cx - hw), clip16(cy - hh), it.ease_mode,
                                  it.frame_count);
      OP_CENTER_CELL: launch_move(clip16(cx * TileW + TileW / 2 - hw),
                                  clip16(cy * TileH + TileH / 2 - hh), it.ease_mode,
                                  it.frame_count);
      OP_JUMP_CELL: begin
        pv_running = 1'b0;
        pos_x = clip16(cx * TileW);
        pos_y = clip16(cy * TileH);
      end
      OP_CANCEL: pv_running = 1'b0;
      OP_TICK:   advance_frame();
      default: ;
    endcase
    r.view_x = pos_x; r.view_y = pos_y; r.busy_res = pv_running;
    expected_views.push_back(r);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  // Valid stays up across back-to-back items; a gap or drain() lowers it.
  task automatic send_item(in_item_t it);
    int g;
    g = long_stalls ? gap_len() : 0;
    @(negedge clk_i);
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_view(it);
    items_sent++;
    if (it.opcode == OP_TICK) ticks_sent++;
  endtask

  // Result checker with random back-pressure.
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= long_stalls ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_views.size() == 0) begin
        $error("result with no expectation: %p", out_item_o);
        fail_count++;
      end else begin
        want = expected_views.pop_front();
        views_checked++;
        if (out_item_o.view_x !== want.view_x) begin
          $error("view_x: expected %0d actual %0d", want.view_x, out_item_o.view_x);
          fail_count++;
        end
        if (out_item_o.view_y !== want.view_y) begin
          $error("view_y: expected %0d actual %0d", want.view_y, out_item_o.view_y);
          fail_count++;
        end
        if (out_item_o.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d actual %0d", want.busy_res, out_item_o.busy_res);
          fail_count++;
        end
      end
    end
  end

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_view_size(logic [11:0] w, logic [11:0] h);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CfgViewW; cfg_data_i <= w;
    @(negedge clk_i);
    cfg_idx_i <= CfgViewH; cfg_data_i <= h;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pv_width = w; pv_height = h;
  endtask

  function automatic in_item_t mk(opcode_e op, int x, int y, ease_e m, int f);
    in_item_t it;
    it.opcode = op; it.coord_x = x[15:0]; it.coord_y = y[15:0];
    it.ease_mode = m; it.frame_count = f[15:0];
    return it;
  endfunction

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return 16'($urandom_range(0, 4000)) - 16'sd2000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Directed: every opcode, every curve, field extremes and saturation.
  task automatic test_directed();
    in_item_t it;
    send_item(mk(OP_TICK, 0, 0, EASE_LINEAR, 5));          // tick while idle
    send_item(mk(OP_SCROLL_TO, 32767, -32768, EASE_INSTANT, 9));
    send_item(mk(OP_SCROLL_TO, 100, 200, EASE_LINEAR, 0)); // zero frames jumps
    send_item(mk(OP_CENTER_ON, -32768, 32767, EASE_INSTANT, 1)); // saturates
    send_item(mk(OP_CENTER_CELL, 32767, -32768, EASE_INSTANT, 1));
    send_item(mk(OP_JUMP_CELL, -32768, 32767, EASE_SMOOTH, 65535));
    send_item(mk(OP_JUMP_CELL, 3, -2, EASE_LINEAR, 4));
    send_item(mk(OP_SCROLL_TO, -32768, 32767, EASE_LINEAR, 3));
    repeat (3) send_item(mk(OP_TICK, 0, 0, EASE_INSTANT, 0));
    send_item(mk(OP_CENTER_ON, 500, -500, EASE_QUAD, 4));
    send_item(mk(OP_TICK, 0, 0, EASE_INSTANT, 0));
    // new command mid-animation restarts from the current position
    send_item(mk(OP_CENTER_CELL, 10, 7, EASE_SMOOTH, 5));
    repeat (2) send_item(mk(OP_TICK, 0, 0, EASE_INSTANT, 0));
    send_item(mk(OP_CANCEL, 1, 1, EASE_QUAD, 1));
    send_item(mk(OP_TICK, 0, 0, EASE_INSTANT, 0));
    send_item(mk(OP_SCROLL_TO, 32767, 32767, EASE_SMOOTH, 65535));
    send_item(mk(OP_TICK, 0, 0, EASE_INSTANT, 0));
    it = mk(OP_TICK, 0, 0, EASE_INSTANT, 0);
    it.opcode = 3'd6; send_item(it);                       // unused opcodes
    it.opcode = 3'd7; send_item(it);
    send_item(mk(OP_CANCEL, 0, 0, EASE_INSTANT, 0));
    drain();
  endtask

  // Random: mostly an eased command followed by a run of ticks, plus noise.
  task automatic test_random(int n_items);
    int sent, k, frames;
    in_item_t it;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        frames = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 12);
        it = mk(opcode_e'($urandom_range(0, 2)), 0, 0, ease_e'($urandom_range(1, 3)), frames);
        it.coord_x = rand_coord(); it.coord_y = rand_coord();
        send_item(it);
        sent++;
        k = $urandom_range(1, 14);
        repeat (k) begin
          it = mk(OP_TICK, 0, 0, EASE_INSTANT, 0);
          it.coord_x = 16'($urandom); it.ease_mode = 2'($urandom);
          it.frame_count = 16'($urandom);
          if ($urandom_range(0, 15) == 0) it.opcode = 3'($urandom_range(0, 7));
          send_item(it);
          sent++;
        end
      end else begin
        it.opcode = 3'($urandom_range(0, 7));
        it.coord_x = rand_coord(); it.coord_y = rand_coord();
        it.ease_mode = 2'($urandom); it.frame_count = 16'($urandom);
        send_item(it);
        sent++;
      end
    end
  endtask

  // Register sweeps: extremes and random sizes, each phase fully drained.
  task automatic test_view_sizes();
    write_view_size(12'd0, 12'd0);
    test_random(150);
    drain();
    write_view_size(12'hfff, 12'hfff);
    test_random(150);
    drain();
    write_view_size(12'($urandom), 12'($urandom));
    test_random(150);
    drain();
    write_view_size(12'd1, 12'hffe);
    test_random(100);
    drain();
  endtask

  initial begin
    pv_width = ViewWReset; pv_height = ViewHReset;
    pos_x = '0; pos_y = '0; org_x = '0; org_y = '0; dst_x = '0; dst_y = '0;
    pv_curve = '0; pv_span = '0; pv_elapsed = '0; pv_running = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    long_stalls = 1'b1;
    test_random(600);
    drain();                 // sender holds off until every result is in
    test_view_sizes();
    long_stalls = 1'b0;
    test_random(60);         // back-to-back stretch with no idling
    drain();
    $display("covered %0d items (%0d frame ticks), %0d results checked,", items_sent,
             ticks_sent, views_checked);
    $display("all opcodes and curves, view sizes from zero to full scale");
    if (fail_count == 0 && expected_views.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/evsa_pkg.sv
hdl/evsa_ctrl.sv
hdl/evsa_dp.sv
hdl/eased_viewport_scroll_animator.sv
tb/eased_viewport_scroll_animator_tb.sv
